// ----- design/rgbyuv_pkg.sv -----
// Shared types and constants for the RGB to YUV 4:2:0 packer.
package rgbyuv_pkg;

	// Line store depth and the widths that follow from it.
	localparam int MAX_GROUPS = 512;
	localparam int GIDX_W     = $clog2(MAX_GROUPS);
	localparam int CFG_W      = 10;
	localparam int CNT_W      = ((CFG_W > GIDX_W) ? CFG_W : GIDX_W) + 1;
	localparam logic [CFG_W-1:0] GPL_RESET = CFG_W'(256);

	// BT.601 luma weights in Q16, and the chroma scale factors.
	localparam int W_R   = 19595;
	localparam int W_G   = 38470;
	localparam int W_B   = 7471;
	localparam int W_ONE = 65536;
	localparam int K_U   = 32244;
	localparam int K_V   = 57475;

	// Luma sum width and the saturation point of the luma sum after the byte shift.
	localparam int LS_W = 24;
	localparam logic [15:0] Y_SAT = 16'(255 * 256);

	// Chroma numerator: the color difference folded into per-channel coefficients.
	localparam int CN_W    = 42;
	localparam int C_SHIFT = 24;
	localparam logic signed [CN_W-1:0] CU_R = CN_W'(-(longint'(K_U) * W_R));
	localparam logic signed [CN_W-1:0] CU_G = CN_W'(-(longint'(K_U) * W_G));
	localparam logic signed [CN_W-1:0] CU_B = CN_W'(longint'(K_U) * (W_ONE - W_B));
	localparam logic signed [CN_W-1:0] CV_R = CN_W'(longint'(K_V) * (W_ONE - W_R));
	localparam logic signed [CN_W-1:0] CV_G = CN_W'(-(longint'(K_V) * W_G));
	localparam logic signed [CN_W-1:0] CV_B = CN_W'(-(longint'(K_V) * W_B));
	localparam logic signed [CN_W-1:0] C_OFS =
		CN_W'(longint'(128) * 255 * (longint'(1) << C_SHIFT));
	localparam logic [16:0] C_SAT = 17'(255 * 256);

	// One four-pixel input group.
	typedef struct packed {
		logic [7:0] red0;
		logic [7:0] green0;
		logic [7:0] blue0;
		logic [7:0] red1;
		logic [7:0] green1;
		logic [7:0] blue1;
		logic [7:0] red2;
		logic [7:0] green2;
		logic [7:0] blue2;
		logic [7:0] red3;
		logic [7:0] green3;
		logic [7:0] blue3;
	} pix_group_t;

	// One result.
	typedef struct packed {
		logic [31:0] luma_word;
		logic [15:0] u_pair;
		logic [15:0] v_pair;
		logic        chroma_valid;
		logic        line_end;
	} result_t;

	// Pair sums of one group as kept in the line store.
	typedef struct packed {
		logic [8:0] v_right;
		logic [8:0] u_right;
		logic [8:0] v_left;
		logic [8:0] u_left;
	} chroma_entry_t;

endpackage

// ----- design/rgbyuv_conv.sv -----
// Converts one RGB pixel to saturated 8-bit Y, U and V.
module rgbyuv_conv (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] y,
	output logic [7:0] u,
	output logic [7:0] v
);

	logic [rgbyuv_pkg::LS_W-1:0]        luma_sum;
	logic [15:0]                        luma_hi;
	logic [16:0]                        luma_div;
	logic signed [rgbyuv_pkg::CN_W-1:0] r_ext;
	logic signed [rgbyuv_pkg::CN_W-1:0] g_ext;
	logic signed [rgbyuv_pkg::CN_W-1:0] b_ext;
	logic signed [rgbyuv_pkg::CN_W-1:0] u_num;
	logic signed [rgbyuv_pkg::CN_W-1:0] v_num;

	// Floors a chroma numerator by 255 * 2^24 and saturates it to a byte.
	// The division by 255 uses the add-and-shift form, exact below 65280.
	function automatic logic [7:0] chroma_byte(input logic signed [rgbyuv_pkg::CN_W-1:0] num);
		logic [16:0] top;
		logic [16:0] quot;
		logic [7:0]  res;
		top  = num[rgbyuv_pkg::C_SHIFT +: 17];
		quot = 17'(top[15:0]) + 17'd1 + 17'(top[15:8]);
		if (num < 0) begin
			res = 8'd0;
		end else if (top >= rgbyuv_pkg::C_SAT) begin
			res = 8'hFF;
		end else begin
			res = quot[15:8];
		end
		return res;
	endfunction

	// Luma: weighted sum, divided by 65280 as a byte shift and a divide by 255.
	always_comb begin
		luma_sum = rgbyuv_pkg::LS_W'(rgbyuv_pkg::W_R) * rgbyuv_pkg::LS_W'(red)
			+ rgbyuv_pkg::LS_W'(rgbyuv_pkg::W_G) * rgbyuv_pkg::LS_W'(green)
			+ rgbyuv_pkg::LS_W'(rgbyuv_pkg::W_B) * rgbyuv_pkg::LS_W'(blue);
		luma_hi  = luma_sum[rgbyuv_pkg::LS_W-1 -: 16];
		luma_div = 17'(luma_hi) + 17'd1 + 17'(luma_hi[15:8]);
		y = (luma_hi >= rgbyuv_pkg::Y_SAT) ? 8'hFF : luma_div[15:8];
	end

	// Chroma: constant-coefficient sums of the three channels plus the offset.
	always_comb begin
		r_ext = $signed(rgbyuv_pkg::CN_W'(red));
		g_ext = $signed(rgbyuv_pkg::CN_W'(green));
		b_ext = $signed(rgbyuv_pkg::CN_W'(blue));
		u_num = rgbyuv_pkg::CU_R * r_ext + rgbyuv_pkg::CU_G * g_ext
			+ rgbyuv_pkg::CU_B * b_ext + rgbyuv_pkg::C_OFS;
		v_num = rgbyuv_pkg::CV_R * r_ext + rgbyuv_pkg::CV_G * g_ext
			+ rgbyuv_pkg::CV_B * b_ext + rgbyuv_pkg::C_OFS;
		u = chroma_byte(u_num);
		v = chroma_byte(v_num);
	end

endmodule

// ----- design/rgb_to_yuv420_packer_unit.sv -----
// Channel   | Direction | Signals                           | Contents
// pix       | in        | pix_valid, pix_ready, pix_data    | one group of four RGB pixels
// res       | out       | res_valid, res_ready, res_data    | packed Y word, chroma pairs, flags
// cfg       | in        | cfg_wr_en, cfg_wr_data            | groups_per_line, no handshake
//
// One group is accepted per cycle unless a stall on the result side has backed up to the input.
// The stages are input register, conversion register with line store read, result register.
// The line store is a single read, single write memory; a same-entry write and read
// in one cycle is served by a bypass register.
// Reset clears the pipeline valids, the bypass flag, the line position and the row parity,
// and sets the width register to 256 groups.
// A stall on the result side backs up stage by stage; holes in the pipeline are filled first.
module rgb_to_yuv420_packer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rgbyuv_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  rgbyuv_pkg::pix_group_t       pix_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output rgbyuv_pkg::result_t          res_data
);

	// Configuration and line position.
	logic [rgbyuv_pkg::CFG_W-1:0]  gpl_q;
	logic [rgbyuv_pkg::GIDX_W-1:0] group_index_q;
	logic                          odd_row_q;
	logic [rgbyuv_pkg::CNT_W-1:0]  gpl_ext;
	logic [rgbyuv_pkg::CNT_W-1:0]  width_eff;
	logic                          last_w;

	// Handshake between stages.
	logic adv1, adv2, adv3;
	logic acc, mov12, mov23, wr_en;

	// Stage one: input register.
	logic                          valid_s1;
	rgbyuv_pkg::pix_group_t        pix_s1;
	logic [rgbyuv_pkg::GIDX_W-1:0] pos_s1;
	logic                          odd_s1;
	logic                          last_s1;
	logic [7:0]                    red_w   [4];
	logic [7:0]                    green_w [4];
	logic [7:0]                    blue_w  [4];
	logic [7:0]                    y_w     [4];
	logic [7:0]                    u_w     [4];
	logic [7:0]                    v_w     [4];
	rgbyuv_pkg::chroma_entry_t     sums_w;

	// Stage two: converted group and line store read.
	logic                          valid_s2;
	logic [31:0]                   luma_s2;
	rgbyuv_pkg::chroma_entry_t     sums_s2;
	logic [rgbyuv_pkg::GIDX_W-1:0] pos_s2;
	logic                          odd_s2;
	logic                          last_s2;
	rgbyuv_pkg::chroma_entry_t     rd_s2;
	logic                          bypass_s2;
	rgbyuv_pkg::chroma_entry_t     bypass_data_s2;
	rgbyuv_pkg::chroma_entry_t     above_w;
	logic [9:0]                    ua_w, va_w, ub_w, vb_w;
	rgbyuv_pkg::result_t           res_w;

	// Stage three: result register.
	logic                          valid_s3;
	rgbyuv_pkg::result_t           res_s3;

	// Line store of even-row pair sums.
	rgbyuv_pkg::chroma_entry_t     line_store_q [rgbyuv_pkg::MAX_GROUPS];

	// Each stage moves when the next one is empty or moving.
	assign adv3      = !valid_s3 || res_ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign pix_ready = adv1;
	assign acc       = pix_valid && pix_ready;
	assign mov12     = valid_s1 && adv2;
	assign mov23     = valid_s2 && adv3;
	assign wr_en     = mov23 && !odd_s2;

	// Effective line width, clamped to 1..MAX_GROUPS, and the line end test.
	always_comb begin
		gpl_ext = rgbyuv_pkg::CNT_W'(gpl_q);
		if (gpl_ext == '0) begin
			width_eff = rgbyuv_pkg::CNT_W'(1);
		end else if (gpl_ext > rgbyuv_pkg::CNT_W'(rgbyuv_pkg::MAX_GROUPS)) begin
			width_eff = rgbyuv_pkg::CNT_W'(rgbyuv_pkg::MAX_GROUPS);
		end else begin
			width_eff = gpl_ext;
		end
		last_w = (rgbyuv_pkg::CNT_W'(group_index_q) + rgbyuv_pkg::CNT_W'(1)) >= width_eff;
	end

	// Width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q <= rgbyuv_pkg::GPL_RESET;
		end else if (cfg_wr_en) begin
			gpl_q <= cfg_wr_data;
		end
	end

	// Position within the line advances on every accepted group; the row parity flips at a line end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_index_q <= '0;
			odd_row_q     <= 1'b0;
		end else if (acc) begin
			if (last_w) begin
				group_index_q <= '0;
				odd_row_q     <= !odd_row_q;
			end else begin
				group_index_q <= group_index_q + 1'b1;
			end
		end
	end

	// Pipeline valids and the bypass flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			bypass_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= pix_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (mov12) begin
				bypass_s2 <= wr_en && (pos_s2 == pos_s1);
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pix_data;
			pos_s1  <= group_index_q;
			odd_s1  <= odd_row_q;
			last_s1 <= last_w;
		end
	end

	// Unpack the group into per-pixel channels.
	always_comb begin
		red_w[0]   = pix_s1.red0;
		green_w[0] = pix_s1.green0;
		blue_w[0]  = pix_s1.blue0;
		red_w[1]   = pix_s1.red1;
		green_w[1] = pix_s1.green1;
		blue_w[1]  = pix_s1.blue1;
		red_w[2]   = pix_s1.red2;
		green_w[2] = pix_s1.green2;
		blue_w[2]  = pix_s1.blue2;
		red_w[3]   = pix_s1.red3;
		green_w[3] = pix_s1.green3;
		blue_w[3]  = pix_s1.blue3;
	end

	// Four pixel converters.
	for (genvar p = 0; p < 4; p++) begin : g_conv
		rgbyuv_conv u_conv (
			.red   (red_w[p]),
			.green (green_w[p]),
			.blue  (blue_w[p]),
			.y     (y_w[p]),
			.u     (u_w[p]),
			.v     (v_w[p])
		);
	end

	// Horizontal pair sums for the left and right 2x2 blocks.
	always_comb begin
		sums_w.u_left  = 9'(u_w[0]) + 9'(u_w[1]);
		sums_w.v_left  = 9'(v_w[0]) + 9'(v_w[1]);
		sums_w.u_right = 9'(u_w[2]) + 9'(u_w[3]);
		sums_w.v_right = 9'(v_w[2]) + 9'(v_w[3]);
	end

	// Stage two payload; the bypass copy holds the sums written in the same cycle.
	always_ff @(posedge clk) begin
		if (mov12) begin
			luma_s2        <= {y_w[3], y_w[2], y_w[1], y_w[0]};
			sums_s2        <= sums_w;
			pos_s2         <= pos_s1;
			odd_s2         <= odd_s1;
			last_s2        <= last_s1;
			bypass_data_s2 <= sums_s2;
		end
	end

	// Line store: even rows write their sums, the read for stage two is registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_store_q[pos_s2] <= sums_s2;
		end
		if (mov12) begin
			rd_s2 <= line_store_q[pos_s1];
		end
	end

	// 2x2 averages on odd rows; even rows emit zero chroma.
	always_comb begin
		above_w = bypass_s2 ? bypass_data_s2 : rd_s2;
		ua_w    = 10'(sums_s2.u_left)  + 10'(above_w.u_left);
		va_w    = 10'(sums_s2.v_left)  + 10'(above_w.v_left);
		ub_w    = 10'(sums_s2.u_right) + 10'(above_w.u_right);
		vb_w    = 10'(sums_s2.v_right) + 10'(above_w.v_right);
		res_w.luma_word    = luma_s2;
		res_w.chroma_valid = odd_s2;
		res_w.line_end     = last_s2;
		if (odd_s2) begin
			res_w.u_pair = {ub_w[9:2], ua_w[9:2]};
			res_w.v_pair = {vb_w[9:2], va_w[9:2]};
		end else begin
			res_w.u_pair = '0;
			res_w.v_pair = '0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (mov23) begin
			res_s3 <= res_w;
		end
	end

	assign res_valid = valid_s3;
	assign res_data  = res_s3;

`ifndef ASSERT_OFF
	// The last group of a line restarts the position and flips the row parity.
	a_line_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_w) |=> (group_index_q == '0 && odd_row_q != $past(odd_row_q)))
		else $error("line end did not wrap the group position");

	// Inside a line the position steps by one and the parity holds.
	a_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !last_w) |=> (group_index_q == rgbyuv_pkg::GIDX_W'($past(group_index_q) + 1'b1)
			&& odd_row_q == $past(odd_row_q)))
		else $error("group position did not advance by one");

	// Even-row results carry no chroma.
	a_even_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.chroma_valid) |-> (res_data.u_pair == '0 && res_data.v_pair == '0))
		else $error("chroma present on an even-row result");
`endif

endmodule
